// ===== rtl/core/ontok_pkg.sv =====
package ontok_pkg;

	// largest integer value, saturation point
	localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

	// result buffer depth, a power of two so that its pointers wrap freely
	localparam int RES_DEPTH = 4;

	// source bytes that matter to the tokenizer
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	typedef enum logic [5:0] {
		TK_INT      = 6'd0,
		TK_FRAC     = 6'd1,
		TK_STR      = 6'd2,
		TK_TILDE    = 6'd3,
		TK_LBRACE   = 6'd4,
		TK_RBRACE   = 6'd5,
		TK_LPAREN   = 6'd6,
		TK_RPAREN   = 6'd7,
		TK_LBRACK   = 6'd8,
		TK_RBRACK   = 6'd9,
		TK_COMMA    = 6'd10,
		TK_DOT      = 6'd11,
		TK_COLON    = 6'd12,
		TK_SEMI     = 6'd13,
		TK_LT       = 6'd14,
		TK_LE       = 6'd15,
		TK_SHL      = 6'd16,
		TK_SHL_EQ   = 6'd17,
		TK_GT       = 6'd18,
		TK_GE       = 6'd19,
		TK_SHR      = 6'd20,
		TK_SHR_EQ   = 6'd21,
		TK_PLUS     = 6'd22,
		TK_INC      = 6'd23,
		TK_PLUS_EQ  = 6'd24,
		TK_MINUS    = 6'd25,
		TK_DEC      = 6'd26,
		TK_MINUS_EQ = 6'd27,
		TK_ARROW    = 6'd28,
		TK_STAR     = 6'd29,
		TK_STAR_EQ  = 6'd30,
		TK_POW      = 6'd31,
		TK_POW_EQ   = 6'd32,
		TK_SLASH    = 6'd33,
		TK_SLASH_EQ = 6'd34,
		TK_AMP      = 6'd35,
		TK_LAND     = 6'd36,
		TK_AMP_EQ   = 6'd37,
		TK_BAR      = 6'd38,
		TK_LOR      = 6'd39,
		TK_BAR_EQ   = 6'd40,
		TK_CARET    = 6'd41,
		TK_CARET_EQ = 6'd42,
		TK_ASSIGN   = 6'd43,
		TK_EQEQ     = 6'd44,
		TK_BANG     = 6'd45,
		TK_NE       = 6'd46
	} tok_kind_t;

	// byte classes seen by the lexer
	typedef enum logic [4:0] {
		CL_OTHER  = 5'd0,
		CL_DIGIT  = 5'd1,
		CL_DOT    = 5'd2,
		CL_LT     = 5'd3,
		CL_GT     = 5'd4,
		CL_PLUS   = 5'd5,
		CL_MINUS  = 5'd6,
		CL_STAR   = 5'd7,
		CL_SLASH  = 5'd8,
		CL_AMP    = 5'd9,
		CL_BAR    = 5'd10,
		CL_CARET  = 5'd11,
		CL_EQ     = 5'd12,
		CL_BANG   = 5'd13,
		CL_QUOTE  = 5'd14,
		CL_NL     = 5'd15,
		CL_SINGLE = 5'd16
	} cls_t;

	// classified word passed from front to back
	typedef struct packed {
		cls_t      cls;
		logic [3:0] digit;
		tok_kind_t single_kind;
		logic      eoi;
	} q_word_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [30:0] value;
		logic        ovf;
		logic        last;
	} res_t;

endpackage

// ===== rtl/core/ontok_front.sv =====
module ontok_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ch,
	input  logic              end_of_input,
	output logic              push_valid,
	input  logic              push_ready,
	output ontok_pkg::q_word_t push_word
);
	import ontok_pkg::*;

	assign push_valid = in_valid;
	assign in_ready   = push_ready;

	// byte classification
	always_comb begin
		push_word.cls         = CL_OTHER;
		push_word.digit       = ch[3:0];
		push_word.single_kind = TK_TILDE;
		push_word.eoi         = end_of_input;
		unique case (ch)
			CH_NL:     push_word.cls = CL_NL;
			CH_BANG:   push_word.cls = CL_BANG;
			CH_QUOTE:  push_word.cls = CL_QUOTE;
			CH_AMP:    push_word.cls = CL_AMP;
			CH_STAR:   push_word.cls = CL_STAR;
			CH_PLUS:   push_word.cls = CL_PLUS;
			CH_MINUS:  push_word.cls = CL_MINUS;
			CH_DOT:    push_word.cls = CL_DOT;
			CH_SLASH:  push_word.cls = CL_SLASH;
			CH_LT:     push_word.cls = CL_LT;
			CH_EQ:     push_word.cls = CL_EQ;
			CH_GT:     push_word.cls = CL_GT;
			CH_CARET:  push_word.cls = CL_CARET;
			CH_BAR:    push_word.cls = CL_BAR;
			CH_TILDE: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_TILDE;
			end
			CH_LBRACE: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_LBRACE;
			end
			CH_RBRACE: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_RBRACE;
			end
			CH_LPAREN: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_LPAREN;
			end
			CH_RPAREN: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_RPAREN;
			end
			CH_LBRACK: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_LBRACK;
			end
			CH_RBRACK: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_RBRACK;
			end
			CH_COMMA: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_COMMA;
			end
			CH_COLON: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_COLON;
			end
			CH_SEMI: begin
				push_word.cls = CL_SINGLE; push_word.single_kind = TK_SEMI;
			end
			default: begin
				if (ch >= CH_0 && ch <= CH_9) begin
					push_word.cls = CL_DIGIT;
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/ontok_queue.sv =====
module ontok_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  ontok_pkg::q_word_t push_word,
	output logic               pop_valid,
	input  logic               pop_ready,
	output ontok_pkg::q_word_t pop_word
);
	import ontok_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_word_t            data_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_word   = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/ontok_lexer.sv =====
module ontok_lexer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  ontok_pkg::q_word_t    q_word,
	input  logic                  room,
	output logic [1:0]            wr_cnt,
	output ontok_pkg::res_t [1:0] wr_data
);
	import ontok_pkg::*;

	typedef enum logic [19:0] {
		LX_IDLE    = 20'h00001,
		LX_INT     = 20'h00002,
		LX_INT_DOT = 20'h00004,
		LX_FRAC    = 20'h00008,
		LX_LT      = 20'h00010,
		LX_SHL     = 20'h00020,
		LX_GT      = 20'h00040,
		LX_SHR     = 20'h00080,
		LX_PLUS    = 20'h00100,
		LX_MINUS   = 20'h00200,
		LX_STAR    = 20'h00400,
		LX_POW     = 20'h00800,
		LX_SLASH   = 20'h01000,
		LX_COMMENT = 20'h02000,
		LX_AMP     = 20'h04000,
		LX_BAR     = 20'h08000,
		LX_CARET   = 20'h10000,
		LX_EQ      = 20'h20000,
		LX_BANG    = 20'h40000,
		LX_STR     = 20'h80000
	} lx_state_t;

	typedef struct packed {
		logic v;
		res_t r;
	} cand_t;

	lx_state_t   state_q;
	logic [30:0] acc_q;
	logic        sat_q;

	lx_state_t   st;
	logic [30:0] acc_w;
	logic        sat_w;
	logic        again;
	logic        do_idle;
	logic        fin;
	tok_kind_t   fin_kind;
	cand_t [3:0] cand;
	logic [1:0]  n;
	res_t [1:0]  out_r;
	logic [34:0] mac;
	logic        pop;
	cls_t        cls;

	function automatic cand_t mk(tok_kind_t k);
		cand_t c;
		c.v       = 1'b1;
		c.r.kind  = k;
		c.r.value = '0;
		c.r.ovf   = 1'b0;
		c.r.last  = 1'b0;
		return c;
	endfunction

	// token left pending in a state when it is closed
	function automatic cand_t pending(lx_state_t s, logic [30:0] acc, logic sat);
		cand_t c;
		c = mk(TK_INT);
		unique case (s)
			LX_INT: begin
				c.r.value = acc;
				c.r.ovf   = sat;
			end
			LX_INT_DOT, LX_FRAC: c.r.kind = TK_FRAC;
			LX_LT:    c.r.kind = TK_LT;
			LX_SHL:   c.r.kind = TK_SHL;
			LX_GT:    c.r.kind = TK_GT;
			LX_SHR:   c.r.kind = TK_SHR;
			LX_PLUS:  c.r.kind = TK_PLUS;
			LX_MINUS: c.r.kind = TK_MINUS;
			LX_STAR:  c.r.kind = TK_STAR;
			LX_POW:   c.r.kind = TK_POW;
			LX_SLASH: c.r.kind = TK_SLASH;
			LX_AMP:   c.r.kind = TK_AMP;
			LX_BAR:   c.r.kind = TK_BAR;
			LX_CARET: c.r.kind = TK_CARET;
			LX_EQ:    c.r.kind = TK_ASSIGN;
			LX_BANG:  c.r.kind = TK_BANG;
			default:  c.v = 1'b0;
		endcase
		return c;
	endfunction

	assign cls     = q_word.cls;
	assign q_ready = room;
	assign pop     = q_valid && room;

	// acc * 10 + digit
	assign mac = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, q_word.digit};

	always_comb begin
		st       = state_q;
		acc_w    = acc_q;
		sat_w    = sat_q;
		again    = 1'b0;
		do_idle  = 1'b0;
		fin      = 1'b0;
		fin_kind = TK_INT;
		cand     = '0;

		unique case (state_q)
			LX_INT: begin
				if (cls == CL_DIGIT) begin
					if (mac > {4'd0, INT_MAX}) begin
						acc_w = INT_MAX;
						sat_w = 1'b1;
					end else begin
						acc_w = mac[30:0];
					end
				end else if (cls == CL_DOT) st = LX_INT_DOT;
				else again = 1'b1;
			end
			LX_INT_DOT, LX_FRAC: begin
				if (cls == CL_DIGIT) st = LX_FRAC;
				else again = 1'b1;
			end
			LX_LT: begin
				if (cls == CL_LT) st = LX_SHL;
				else if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_LE; end
				else again = 1'b1;
			end
			LX_SHL: begin
				if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_SHL_EQ; end
				else again = 1'b1;
			end
			LX_GT: begin
				if (cls == CL_GT) st = LX_SHR;
				else if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_GE; end
				else again = 1'b1;
			end
			LX_SHR: begin
				if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_SHR_EQ; end
				else again = 1'b1;
			end
			LX_PLUS: begin
				if (cls == CL_PLUS) begin fin = 1'b1; fin_kind = TK_INC; end
				else if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_PLUS_EQ; end
				else again = 1'b1;
			end
			LX_MINUS: begin
				if (cls == CL_MINUS) begin fin = 1'b1; fin_kind = TK_DEC; end
				else if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_MINUS_EQ; end
				else if (cls == CL_GT) begin fin = 1'b1; fin_kind = TK_ARROW; end
				else again = 1'b1;
			end
			LX_STAR: begin
				if (cls == CL_STAR) st = LX_POW;
				else if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_STAR_EQ; end
				else again = 1'b1;
			end
			LX_POW: begin
				if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_POW_EQ; end
				else again = 1'b1;
			end
			LX_SLASH: begin
				if (cls == CL_SLASH) st = LX_COMMENT;
				else if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_SLASH_EQ; end
				else again = 1'b1;
			end
			LX_COMMENT: begin
				if (cls == CL_NL) st = LX_IDLE;
			end
			LX_AMP: begin
				if (cls == CL_AMP) begin fin = 1'b1; fin_kind = TK_LAND; end
				else if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_AMP_EQ; end
				else again = 1'b1;
			end
			LX_BAR: begin
				if (cls == CL_BAR) begin fin = 1'b1; fin_kind = TK_LOR; end
				else if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_BAR_EQ; end
				else again = 1'b1;
			end
			LX_CARET: begin
				if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_CARET_EQ; end
				else again = 1'b1;
			end
			LX_EQ: begin
				if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_EQEQ; end
				else again = 1'b1;
			end
			LX_BANG: begin
				if (cls == CL_EQ) begin fin = 1'b1; fin_kind = TK_NE; end
				else again = 1'b1;
			end
			LX_STR: begin
				if (cls == CL_QUOTE) begin fin = 1'b1; fin_kind = TK_STR; end
			end
			default: begin
				st      = LX_IDLE;
				do_idle = 1'b1;
			end
		endcase

		if (fin) begin
			cand[0] = mk(fin_kind);
			st      = LX_IDLE;
		end

		// byte closes the pending token, then starts afresh
		if (again) begin
			cand[1] = pending(state_q, acc_q, sat_q);
			st      = LX_IDLE;
			acc_w   = '0;
			sat_w   = 1'b0;
			do_idle = 1'b1;
		end

		if (do_idle) begin
			unique case (cls)
				CL_LT:     st = LX_LT;
				CL_GT:     st = LX_GT;
				CL_PLUS:   st = LX_PLUS;
				CL_MINUS:  st = LX_MINUS;
				CL_STAR:   st = LX_STAR;
				CL_SLASH:  st = LX_SLASH;
				CL_AMP:    st = LX_AMP;
				CL_BAR:    st = LX_BAR;
				CL_CARET:  st = LX_CARET;
				CL_EQ:     st = LX_EQ;
				CL_BANG:   st = LX_BANG;
				CL_QUOTE:  st = LX_STR;
				CL_SINGLE: cand[2] = mk(q_word.single_kind);
				CL_DOT:    cand[2] = mk(TK_DOT);
				CL_DIGIT: begin
					st    = LX_INT;
					acc_w = {27'd0, q_word.digit};
					sat_w = 1'b0;
				end
				default: ;
			endcase
		end

		// end of input flush
		if (q_word.eoi) begin
			cand[3] = pending(st, acc_w, sat_w);
			st      = LX_IDLE;
			acc_w   = '0;
			sat_w   = 1'b0;
		end
	end

	// pack up to two results in order and mark the final one
	always_comb begin
		n     = '0;
		out_r = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i].v && n != 2'd2) begin
				out_r[n[0]] = cand[i].r;
				n           = n + 2'd1;
			end
		end
		if (n == 2'd1) out_r[0].last = 1'b1;
		else if (n == 2'd2) out_r[1].last = 1'b1;
	end

	assign wr_cnt  = pop ? n : 2'd0;
	assign wr_data = out_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LX_IDLE;
			acc_q   <= '0;
			sat_q   <= 1'b0;
		end else if (pop) begin
			state_q <= st;
			acc_q   <= acc_w;
			sat_q   <= sat_w;
		end
	end

endmodule

// ===== rtl/core/ontok_resbuf.sv =====
module ontok_resbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            wr_cnt,
	input  ontok_pkg::res_t [1:0] wr_data,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [5:0]            token_kind,
	output logic [30:0]           int_value,
	output logic                  overflow,
	output logic                  last
);
	import ontok_pkg::*;

	localparam int PTR_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	res_t             data_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	res_t             head;

	// space for the two results one word may cause
	assign room      = (count_q <= CNT_W'(RES_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = data_q[rd_ptr_q];

	assign token_kind = head.kind;
	assign int_value  = head.value;
	assign overflow   = head.ovf;
	assign last       = head.last;

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			data_q[wr_ptr_q] <= wr_data[0];
		end
		if (wr_cnt == 2'd2) begin
			data_q[wr_ptr_q + PTR_W'(1)] <= wr_data[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(wr_cnt);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(wr_cnt) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/operator_number_tokenizer_core.sv =====
// operator and number tokenizer, one source byte per input word
// input channel: in_valid/in_ready carry ch and end_of_input; a word is taken
//   when both are high; end_of_input marks the last byte and flushes any
//   pending integer, fraction or operator after that byte
// output channel: out_valid/out_ready carry token_kind, int_value, overflow
//   and last; a byte yields zero, one or two words, last set on the final one
// front: classifies the byte and writes it into a small queue (QUEUE_DEPTH)
// back: lexer state machine pops one queue entry per cycle while the result
//   buffer has room for two words, updates the integer accumulator (x10 plus
//   digit, saturating) and writes results into a four-entry result buffer
//   that drives the output ports directly
// path: a taken byte is registered in the queue, then the lexer writes its
//   words into the result buffer registers, which raise out_valid
// throughput: one byte per cycle while the result buffer has room for two
//   words; output of one word per cycle sets the pace for two-word bytes
// receiver stall: the result buffer fills, the lexer stops popping, the
//   queue fills, then in_ready drops; nothing is lost or repeated
// reset: arst_n clears the lexer to idle, the accumulator and flag to zero,
//   and empties queue and buffer
module operator_number_tokenizer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [30:0] int_value,
	output logic        overflow,
	output logic        last
);
	import ontok_pkg::*;

	// front to queue
	logic       push_valid;
	logic       push_ready;
	q_word_t    push_word;

	// queue to lexer
	logic       q_valid;
	logic       q_ready;
	q_word_t    q_word;

	// lexer to result buffer
	logic       room;
	logic [1:0] wr_cnt;
	res_t [1:0] wr_data;

	ontok_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.ch           (ch),
		.end_of_input (end_of_input),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_word    (push_word)
	);

	// decouples byte intake from lexer stalls
	ontok_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_word   (q_word)
	);

	ontok_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_word  (q_word),
		.room    (room),
		.wr_cnt  (wr_cnt),
		.wr_data (wr_data)
	);

	// output register stage, parts lexer from the receiver
	ontok_resbuf u_resbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_cnt     (wr_cnt),
		.wr_data    (wr_data),
		.room       (room),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_kind (token_kind),
		.int_value  (int_value),
		.overflow   (overflow),
		.last       (last)
	);

endmodule
